// ----- hdl/sem_pkg.sv -----
// Shared types and constants for the Sobel edge magnitude block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package sem_pkg;

    // Field widths of the two streams.
    localparam int PIX_W  = 8;
    localparam int EDGE_W = 8;
    localparam int COL_W  = 11;
    localparam int ROW_W  = 12;

    // Configuration registers.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int IMG_W_BITS = 12;
    localparam int IMG_H_BITS = 13;
    localparam logic [IMG_W_BITS-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [IMG_H_BITS-1:0] HEIGHT_RESET = 13'd480;
    localparam int MIN_DIM    = 3;
    localparam int MAX_HEIGHT = 4096;

    // Datapath widths.
    localparam int ABS_W      = 10;  // magnitude of one gradient, at most 1020
    localparam int SQ_W       = 20;  // square of one gradient magnitude
    localparam int ENERGY_W   = 16;  // gradient energy after saturation
    localparam int SQRT_STEPS = 8;   // one result bit per pipeline stage

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } sem_reg_t;

    // Position and frame mark that ride along with each result.
    typedef struct packed {
        logic [COL_W-1:0] out_col;
        logic [ROW_W-1:0] out_row;
        logic             frame_end;
    } sem_tag_t;

endpackage

`default_nettype wire

// ----- hdl/sem_if.sv -----
// Stream interfaces of the Sobel edge magnitude block: pixel input and edge result.
// Depends on sem_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface sem_pixel_if import sem_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface sem_edge_if import sem_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [EDGE_W-1:0] edge_value;
    logic [COL_W-1:0]  out_col;
    logic [ROW_W-1:0]  out_row;
    logic              frame_end;

    modport source (output valid, output edge_value, output out_col, output out_row,
                    output frame_end, input ready);
    modport sink   (input valid, input edge_value, input out_col, input out_row,
                    input frame_end, output ready);
endinterface

`default_nettype wire

// ----- hdl/sem_isqrt.sv -----
// Pipelined integer square root, one result bit per stage, with a tag carried alongside.
// Depends on sem_pkg for widths and the tag type.
`timescale 1ns / 1ps
`default_nettype none

module sem_isqrt import sem_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ENERGY_W-1:0] in_energy,
    input  sem_tag_t            in_tag,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [EDGE_W-1:0]   out_root,
    output sem_tag_t            out_tag
);

    localparam int NS = SQRT_STEPS;
    localparam int RW = EDGE_W + 2;  // remainder never exceeds twice the root

    logic                v_reg    [NS];
    logic [RW-1:0]       rem_reg  [NS];
    logic [EDGE_W-1:0]   root_reg [NS];
    logic [ENERGY_W-1:0] e_reg    [NS];
    sem_tag_t            tag_reg  [NS];
    logic                rdy      [NS];

    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_stage
            logic                src_v;
            logic [RW-1:0]       src_rem;
            logic [EDGE_W-1:0]   src_root;
            logic [ENERGY_W-1:0] src_e;
            sem_tag_t            src_tag;
            logic [RW+1:0]       rem_sh;
            logic [RW+1:0]       trial;
            logic [RW-1:0]       rem_next;
            logic [EDGE_W-1:0]   root_next;

            if (k == 0) begin : g_first
                assign src_v    = in_valid;
                assign src_rem  = '0;
                assign src_root = '0;
                assign src_e    = in_energy;
                assign src_tag  = in_tag;
            end else begin : g_inner
                assign src_v    = v_reg[k-1];
                assign src_rem  = rem_reg[k-1];
                assign src_root = root_reg[k-1];
                assign src_e    = e_reg[k-1];
                assign src_tag  = tag_reg[k-1];
            end

            if (k == NS - 1) begin : g_last_rdy
                assign rdy[k] = !v_reg[k] || out_ready;
            end else begin : g_mid_rdy
                assign rdy[k] = !v_reg[k] || rdy[k+1];
            end

            // Bring down the next two bits of the radicand and try the next root bit.
            always_comb
            begin
                rem_sh = {src_rem, src_e[ENERGY_W-1 -: 2]};
                trial  = (RW+2)'({src_root, 2'b01});
                if (rem_sh >= trial)
                begin
                    rem_next  = RW'(rem_sh - trial);
                    root_next = {src_root[EDGE_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = RW'(rem_sh);
                    root_next = {src_root[EDGE_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (rdy[k])
                begin
                    v_reg[k] <= src_v;
                end
            end

            always_ff @(posedge clk)
            begin
                if (rdy[k] && src_v)
                begin
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                    e_reg[k]    <= {src_e[ENERGY_W-3:0], 2'b00};
                    tag_reg[k]  <= src_tag;
                end
            end
        end
    endgenerate

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NS-1];
    assign out_root  = root_reg[NS-1];
    assign out_tag   = tag_reg[NS-1];

endmodule

`default_nettype wire

// ----- hdl/sobel_edge_magnitude_top.sv -----
// Top level of the streaming 3x3 Sobel edge magnitude block.
// Depends on sem_pkg, the stream interfaces in sem_if.sv and the sem_isqrt pipeline.
`timescale 1ns / 1ps
`default_nettype none

// Channel    Kind          Handshake      Payload
// pixel_ch   stream in     valid/ready    pixel (8 bits, raster order)
// edge_ch    stream out    valid/ready    edge_value, out_col, out_row, frame_end
// APB        register port psel/penable   image_width at 0x0, image_height at 0x4
//
// One pixel request can be taken every clock cycle unless the pipeline stalls;
// a result passes through line store read, window, gradients, squares and eight
// square root stages. Every stage carries its own valid bit and holds while the
// stage after it is full, so backpressure on edge_ch stalls nothing until the
// pipeline has no bubble left. Reset clears the counters, the valid bits and the
// configuration (640 by 480); the line stores need no clearing pass.

module sobel_edge_magnitude_top import sem_pkg::*; #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    sem_pixel_if.sink             pixel_ch,
    sem_edge_if.source            edge_ch
);

    // Column counter width, clamp width for the programmed row length, and
    // the width in which the result column is formed.
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = (CW + 1 > IMG_W_BITS) ? CW + 1 : IMG_W_BITS;
    localparam int TW = (CW > COL_W) ? CW : COL_W;

    // ------------------------------------------------------------------
    // Configuration registers. A write restarts the frame.
    // ------------------------------------------------------------------
    logic [IMG_W_BITS-1:0] width_reg;
    logic [IMG_H_BITS-1:0] height_reg;
    logic                  cfg_wr;
    sem_reg_t              reg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = sem_reg_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[IMG_W_BITS-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[IMG_H_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(height_reg);
            default:          prdata = '0;
        endcase
    end

    // Programmed sizes are clamped into the range the hardware supports; only
    // the last column and last row indexes are needed downstream.
    logic [EW-1:0]         w_ext;
    logic [EW-1:0]         w_eff;
    logic [IMG_H_BITS-1:0] h_eff;
    logic [CW-1:0]         last_col;
    logic [ROW_W-1:0]      last_row;

    always_comb
    begin
        w_ext = EW'(width_reg);
        if (w_ext < EW'(MIN_DIM))
        begin
            w_eff = EW'(MIN_DIM);
        end
        else if (w_ext > EW'(MAX_WIDTH))
        begin
            w_eff = EW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = w_ext;
        end

        if (height_reg < IMG_H_BITS'(MIN_DIM))
        begin
            h_eff = IMG_H_BITS'(MIN_DIM);
        end
        else if (height_reg > IMG_H_BITS'(MAX_HEIGHT))
        begin
            h_eff = IMG_H_BITS'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = height_reg;
        end

        last_col = CW'(w_eff - EW'(1));
        last_row = ROW_W'(h_eff - IMG_H_BITS'(1));
    end

    // ------------------------------------------------------------------
    // Pipeline handshake: each stage loads when it is empty or its
    // successor is loading.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;
    logic sq_in_ready;
    logic in_acc;

    assign rdy4 = !v4_reg || sq_in_ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign pixel_ch.ready = rdy1;
    assign in_acc         = pixel_ch.valid && rdy1;

    // ------------------------------------------------------------------
    // Position counters of the incoming pixel.
    // ------------------------------------------------------------------
    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_wr)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (in_acc)
        begin
            if (col_reg == last_col)
            begin
                col_next = '0;
                row_next = (row_reg == last_row) ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // The result of the window completed by this pixel belongs to the center,
    // one column left and one row up. Only interior centers produce a result.
    logic [TW-1:0] col_wide;
    logic          emit_now;
    sem_tag_t      tag_now;

    always_comb
    begin
        col_wide          = TW'(col_reg) - TW'(1);
        emit_now          = (col_reg >= CW'(2)) && (row_reg >= ROW_W'(2));
        tag_now.out_col   = col_wide[COL_W-1:0];
        tag_now.out_row   = row_reg - ROW_W'(1);
        tag_now.frame_end = (col_reg == last_col) && (row_reg == last_row);
    end

    // ------------------------------------------------------------------
    // Stage 1: line stores. Reads are registered. The middle store takes the
    // new pixel right away; the upper store takes the old middle value in the
    // next cycle, from the registered read data. A row is at least three
    // pixels long, so that column is not read again before the write lands.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
    logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
    logic [PIX_W-1:0] rd_up_reg;
    logic [PIX_W-1:0] rd_mid_reg;
    logic             upd_pend_reg;
    logic [CW-1:0]    upd_addr_reg;
    logic [PIX_W-1:0] pix1_reg;
    logic             emit1_reg;
    sem_tag_t         tag1_reg;

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            rd_up_reg           <= upper_mem[col_reg];
            rd_mid_reg          <= middle_mem[col_reg];
            middle_mem[col_reg] <= pixel_ch.pixel;
        end
        if (upd_pend_reg)
        begin
            upper_mem[upd_addr_reg] <= rd_mid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upd_pend_reg <= 1'b0;
            v1_reg       <= 1'b0;
        end
        else
        begin
            upd_pend_reg <= in_acc;
            if (rdy1)
            begin
                v1_reg <= pixel_ch.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            upd_addr_reg <= col_reg;
            pix1_reg     <= pixel_ch.pixel;
            emit1_reg    <= emit_now;
            tag1_reg     <= tag_now;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the 3x3 window. It shifts one column left for every pixel;
    // row 0 is the oldest line, row 2 the incoming one. Pixels whose center
    // lies on the border leave the pipeline here.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] win_reg [3][3];
    sem_tag_t         tag2_reg;
    logic             shift1;

    assign shift1 = rdy2 && v1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (rdy2)
        begin
            v2_reg <= v1_reg && emit1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift1)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= rd_up_reg;
            win_reg[1][2] <= rd_mid_reg;
            win_reg[2][2] <= pix1_reg;
            tag2_reg      <= tag1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: gradient magnitudes. Each kernel is a difference of two
    // weighted column or row sums; only the magnitude matters for the square.
    // ------------------------------------------------------------------
    logic [ABS_W-1:0] gx_pos, gx_neg, gy_pos, gy_neg;
    logic [ABS_W-1:0] agx_reg, agy_reg;
    sem_tag_t         tag3_reg;

    always_comb
    begin
        gx_pos = ABS_W'(win_reg[0][2]) + ABS_W'({win_reg[1][2], 1'b0})
               + ABS_W'(win_reg[2][2]);
        gx_neg = ABS_W'(win_reg[0][0]) + ABS_W'({win_reg[1][0], 1'b0})
               + ABS_W'(win_reg[2][0]);
        gy_pos = ABS_W'(win_reg[2][0]) + ABS_W'({win_reg[2][1], 1'b0})
               + ABS_W'(win_reg[2][2]);
        gy_neg = ABS_W'(win_reg[0][0]) + ABS_W'({win_reg[0][1], 1'b0})
               + ABS_W'(win_reg[0][2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (rdy3)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            agx_reg  <= (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
            agy_reg  <= (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
            tag3_reg <= tag2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: squares, one multiplier per gradient.
    // ------------------------------------------------------------------
    logic [SQ_W-1:0] sqx_reg, sqy_reg;
    sem_tag_t        tag4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (rdy4)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4 && v3_reg)
        begin
            sqx_reg  <= SQ_W'(agx_reg) * SQ_W'(agx_reg);
            sqy_reg  <= SQ_W'(agy_reg) * SQ_W'(agy_reg);
            tag4_reg <= tag3_reg;
        end
    end

    // Energy at or above 2^16 has a root of at least 256, which saturates to
    // 255 just as the largest 16-bit energy does, so clamping it is exact.
    logic [SQ_W:0]         energy_full;
    logic [ENERGY_W-1:0]   energy_sat;

    always_comb
    begin
        energy_full = (SQ_W+1)'(sqx_reg) + (SQ_W+1)'(sqy_reg);
        if (energy_full[SQ_W:ENERGY_W] != '0)
        begin
            energy_sat = '1;
        end
        else
        begin
            energy_sat = energy_full[ENERGY_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stages 5 to 12: square root; its last stage is the output register.
    // ------------------------------------------------------------------
    sem_tag_t out_tag;

    sem_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .in_ready  (sq_in_ready),
        .in_energy (energy_sat),
        .in_tag    (tag4_reg),
        .out_valid (edge_ch.valid),
        .out_ready (edge_ch.ready),
        .out_root  (edge_ch.edge_value),
        .out_tag   (out_tag)
    );

    assign edge_ch.out_col   = out_tag.out_col;
    assign edge_ch.out_row   = out_tag.out_row;
    assign edge_ch.frame_end = out_tag.frame_end;

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for the streaming 3x3 Sobel edge magnitude block.
// Depends on sem_pkg, the stream interfaces in sem_if.sv and sobel_edge_magnitude_top.
`timescale 1ns / 1ps

module tb;
    import sem_pkg::*;

    localparam int LINE_DEPTH  = 2048;  // line store depth, also the widest usable row
    localparam int SETTLE_CYC  = 24;    // settling time after the queues have drained
    localparam int HOLD_CYC    = 300;   // long output hold-off used once to back up the pipe
    localparam int STALL_LIMIT = 4000;  // cycles without any accepted request before giving up
    localparam int PHASE_ITEMS = 250;

    typedef enum int {
        FILL_NOISE,
        FILL_FLAT,
        FILL_BINARY,
        FILL_RAMP,
        FILL_WEDGE
    } fill_t;

    typedef struct packed {
        logic [EDGE_W-1:0] edge_value;
        sem_tag_t          tag;
    } edge_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    sem_pixel_if pixel_ch ();
    sem_edge_if  edge_ch ();

    sobel_edge_magnitude_top #(
        .MAX_WIDTH (LINE_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .pixel_ch (pixel_ch),
        .edge_ch  (edge_ch)
    );

    always #5 clk = ~clk;

    // Stimulus and expectations.
    logic [PIX_W-1:0] pixel_feed [$];
    edge_result_t     expected_edges [$];
    edge_result_t     next_edge;

    // Shadow of the block: configuration, raster position, line stores and window.
    logic [IMG_W_BITS-1:0] width_cfg;
    logic [IMG_H_BITS-1:0] height_cfg;
    int                    col_pos;
    int                    row_pos;
    logic [PIX_W-1:0]      upper_row_mem [LINE_DEPTH];
    logic [PIX_W-1:0]      middle_row_mem [LINE_DEPTH];
    logic [PIX_W-1:0]      kernel_win [3][3];

    int  send_idle_pct = 0;
    int  stall_pct = 0;
    int  hold_asked = 0;
    int  hold_served = 0;
    int  hold_left = 0;
    int  error_count = 0;
    int  idle_cycles = 0;
    bit  pixel_taken = 1'b0;

    function automatic int width_eff();
        if (width_cfg < MIN_DIM)
            return MIN_DIM;
        if (width_cfg > LINE_DEPTH)
            return LINE_DEPTH;
        return int'(width_cfg);
    endfunction

    function automatic int height_eff();
        if (height_cfg < MIN_DIM)
            return MIN_DIM;
        if (height_cfg > MAX_HEIGHT)
            return MAX_HEIGHT;
        return int'(height_cfg);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    // Advance the shadow by one accepted pixel and queue the edge result it produces.
    task automatic sobel_predict(input logic [PIX_W-1:0] px);
        int           w;
        int           h;
        int           ci;
        int           i;
        int           j;
        int           gx;
        int           gy;
        int unsigned  energy;
        int unsigned  root;
        int unsigned  trial;
        int unsigned  bitv;
        int           q [3][3];
        edge_result_t res;
        w  = width_eff();
        h  = height_eff();
        ci = col_pos % LINE_DEPTH;
        for (i = 0; i < 3; i++)
        begin
            kernel_win[i][0] = kernel_win[i][1];
            kernel_win[i][1] = kernel_win[i][2];
        end
        kernel_win[0][2]   = upper_row_mem[ci];
        kernel_win[1][2]   = middle_row_mem[ci];
        kernel_win[2][2]   = px;
        upper_row_mem[ci]  = middle_row_mem[ci];
        middle_row_mem[ci] = px;
        if (col_pos >= 2 && row_pos >= 2)
        begin
            for (i = 0; i < 3; i++)
                for (j = 0; j < 3; j++)
                    q[i][j] = int'(kernel_win[i][j]);
            gx = (q[0][2] + 2 * q[1][2] + q[2][2]) - (q[0][0] + 2 * q[1][0] + q[2][0]);
            gy = (q[2][0] + 2 * q[2][1] + q[2][2]) - (q[0][0] + 2 * q[0][1] + q[0][2]);
            energy = gx * gx + gy * gy;
            // Bitwise floor square root; anything at or above 256 squared saturates.
            if (energy >= 65536)
                root = 255;
            else
            begin
                root = 0;
                for (bitv = 128; bitv != 0; bitv = bitv >> 1)
                begin
                    trial = root | bitv;
                    if (trial * trial <= energy)
                        root = trial;
                end
            end
            res.edge_value    = EDGE_W'(root);
            res.tag.out_col   = COL_W'(col_pos - 1);
            res.tag.out_row   = ROW_W'(row_pos - 1);
            res.tag.frame_end = (col_pos + 1 == w) && (row_pos + 1 == h);
            expected_edges.push_back(res);
        end
        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h)
                row_pos = 0;
        end
    endtask

    // Register write over APB: setup cycle, then access cycle until pready.
    // Bits above the register width carry random junk that the block must drop.
    task automatic write_reg(input sem_reg_t idx, input int unsigned value);
        int unsigned mask;
        mask = (idx == REG_IMAGE_WIDTH) ? ((1 << IMG_W_BITS) - 1) : ((1 << IMG_H_BITS) - 1);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * int'(idx));
        pwdata  <= ($urandom & ~mask) | (value & mask);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == REG_IMAGE_WIDTH)
            width_cfg = IMG_W_BITS'(value);
        else
            height_cfg = IMG_H_BITS'(value);
        // Any register write restarts the frame; the line stores keep their contents.
        col_pos = 0;
        row_pos = 0;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Queue count pixels laid out in raster order over a w by h frame.
    task automatic queue_pixels(input int count, input int w, input int h, input fill_t mode,
                                input int base, input int stride);
        int               k;
        int               c;
        int               r;
        logic [PIX_W-1:0] px;
        for (k = 0; k < count; k++)
        begin
            c = k % w;
            r = (k / w) % h;
            case (mode)
                FILL_NOISE:  px = PIX_W'($urandom_range(255));
                FILL_FLAT:   px = PIX_W'(base + $urandom_range(15));
                FILL_BINARY: px = $urandom_range(1) ? 8'hFF : 8'h00;
                FILL_RAMP:   px = PIX_W'(c * stride + 3 * r + $urandom_range(3));
                default:     px = (c + r >= w - 1) ? 8'hFF : PIX_W'(c * 40 + r * 10);
            endcase
            pixel_feed.push_back(px);
        end
    endtask

    // Wait until every queued pixel is taken and every expected result has come back,
    // then give trailing border pixels time to clear the pipeline.
    task automatic settle();
        while (pixel_feed.size() != 0 || pixel_ch.valid || expected_edges.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Pixel driver: presents the next queued pixel at the falling edge, holds it until taken.
    always @(negedge clk)
    begin
        if (!rst_n)
            pixel_ch.valid <= 1'b0;
        else if (!pixel_ch.valid || pixel_taken)
        begin
            if (pixel_feed.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                pixel_ch.valid <= 1'b1;
                pixel_ch.pixel <= pixel_feed.pop_front();
            end
            else
                pixel_ch.valid <= 1'b0;
        end
    end

    // Result receiver: random stalls, plus one long hold-off on request from the stimulus.
    always @(negedge clk)
    begin
        if (!rst_n)
            edge_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            edge_ch.ready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (hold_served != hold_asked)
        begin
            edge_ch.ready <= 1'b0;
            hold_left     <= HOLD_CYC;
            hold_served   <= hold_served + 1;
        end
        else
            edge_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Monitor: predicts on every accepted pixel and checks every accepted result.
    always @(posedge clk)
    begin
        pixel_taken <= pixel_ch.valid && pixel_ch.ready;
        if (rst_n && pixel_ch.valid && pixel_ch.ready)
            sobel_predict(pixel_ch.pixel);
        if (rst_n && edge_ch.valid && edge_ch.ready)
        begin
            if (expected_edges.size() == 0)
                report_mismatch($sformatf("unexpected result col %0d row %0d value %0d",
                                          edge_ch.out_col, edge_ch.out_row, edge_ch.edge_value));
            else
            begin
                next_edge = expected_edges.pop_front();
                if (edge_ch.edge_value !== next_edge.edge_value)
                    report_mismatch($sformatf("edge_value at col %0d row %0d: got %0d want %0d",
                                              next_edge.tag.out_col, next_edge.tag.out_row,
                                              edge_ch.edge_value, next_edge.edge_value));
                if (edge_ch.out_col !== next_edge.tag.out_col)
                    report_mismatch($sformatf("out_col: got %0d want %0d",
                                              edge_ch.out_col, next_edge.tag.out_col));
                if (edge_ch.out_row !== next_edge.tag.out_row)
                    report_mismatch($sformatf("out_row: got %0d want %0d",
                                              edge_ch.out_row, next_edge.tag.out_row));
                if (edge_ch.frame_end !== next_edge.tag.frame_end)
                    report_mismatch($sformatf("frame_end at col %0d row %0d: got %0b want %0b",
                                              next_edge.tag.out_col, next_edge.tag.out_row,
                                              edge_ch.frame_end, next_edge.tag.frame_end));
            end
        end
    end

    // Watchdog: too long without any accepted request means the block is hung.
    always @(posedge clk)
    begin
        if (!rst_n || (pixel_ch.valid && pixel_ch.ready) || (edge_ch.valid && edge_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int send_pcts [4];
        int stall_pcts [4];
        int phase;
        int phase_items;
        int pick;
        int which;
        int w;
        int h;
        int span;
        int count;
        int w_val;
        int h_val;
        send_pcts  = '{0, 64, 0, 33};
        stall_pcts = '{0, 0, 64, 33};

        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        pixel_ch.valid = 1'b0;
        pixel_ch.pixel = '0;
        edge_ch.ready  = 1'b0;
        width_cfg      = WIDTH_RESET;
        height_cfg     = HEIGHT_RESET;
        col_pos        = 0;
        row_pos        = 0;
        for (int i = 0; i < LINE_DEPTH; i++)
        begin
            upper_row_mem[i]  = '0;
            middle_row_mem[i] = '0;
        end
        for (int i = 0; i < 9; i++)
            kernel_win[i / 3][i % 3] = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset configuration (640 by 480): the start of the first row, which gives
        // no result and must produce none.
        queue_pixels(60, 640, 480, FILL_NOISE, 0, 0);
        settle();

        // Directed: a 5x5 frame with a saturating diagonal edge and a ramp,
        // then sizes below the minimum, which clamp to the smallest 3x3 frame.
        write_reg(REG_IMAGE_WIDTH, 5);
        write_reg(REG_IMAGE_HEIGHT, 5);
        queue_pixels(25, 5, 5, FILL_WEDGE, 0, 0);
        settle();
        write_reg(REG_IMAGE_WIDTH, 0);
        write_reg(REG_IMAGE_HEIGHT, 1);
        queue_pixels(9, 3, 3, FILL_WEDGE, 0, 0);
        queue_pixels(9, 3, 3, FILL_FLAT, 240, 0);
        settle();

        for (phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = send_pcts[phase];
            stall_pct     = stall_pcts[phase];
            phase_items   = 0;
            if (phase == 0)
            begin
                // Widths above the line store clamp to its depth; only the start of
                // the first row is streamed.
                write_reg(REG_IMAGE_WIDTH, (1 << IMG_W_BITS) - 1);
                write_reg(REG_IMAGE_HEIGHT, 2);
                queue_pixels(100, LINE_DEPTH, 3, FILL_NOISE, 0, 0);
                settle();
                // Tallest frame, narrowest rows; only its top part is streamed.
                write_reg(REG_IMAGE_WIDTH, 2);
                write_reg(REG_IMAGE_HEIGHT, (1 << IMG_H_BITS) - 1);
                queue_pixels(150, 3, MAX_HEIGHT, FILL_RAMP, 0, 40);
                settle();
                // Back-pressure: the receiver holds off while a whole frame is offered,
                // so the pipeline fills and the pixel stream must stall.
                write_reg(REG_IMAGE_WIDTH, 20);
                write_reg(REG_IMAGE_HEIGHT, 12);
                queue_pixels(240, 20, 12, FILL_NOISE, 0, 0);
                hold_asked++;
                settle();
            end
            while (phase_items < PHASE_ITEMS)
            begin
                // New configuration for every run of frames; one in ten width values and
                // two in ten height values are out of range.
                pick  = $urandom_range(9);
                w_val = (pick == 0) ? $urandom_range(2) : $urandom_range(24, 3);
                pick  = $urandom_range(9);
                if (pick == 0)
                    h_val = $urandom_range(2);
                else if (pick == 1)
                    h_val = $urandom_range((1 << IMG_H_BITS) - 1, MAX_HEIGHT + 1);
                else
                    h_val = $urandom_range(10, 3);
                which = $urandom_range(2);
                if (which != 1 || width_eff() > 24)
                    write_reg(REG_IMAGE_WIDTH, w_val);
                if (which != 0)
                    write_reg(REG_IMAGE_HEIGHT, h_val);
                w = width_eff();
                h = height_eff();
                // Mostly whole frames back to back (frame wrap); the rest stop mid-frame
                // and the next register write restarts the frame.
                if (h <= 12 && $urandom_range(9) < 7)
                    count = w * h * $urandom_range(3, 1);
                else
                begin
                    span  = w * ((h < 12) ? h : 12);
                    count = $urandom_range(span - 1, 1);
                end
                // The last run of a phase is cut to its remaining share of pixels.
                if (count > PHASE_ITEMS - phase_items)
                    count = PHASE_ITEMS - phase_items;
                queue_pixels(count, w, h, fill_t'($urandom_range(3)),
                             $urandom_range(240), $urandom_range(24));
                phase_items += count;
                settle();
            end
        end

        settle();
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/sem_pkg.sv
hdl/sem_if.sv
hdl/sem_isqrt.sv
hdl/sobel_edge_magnitude_top.sv
sim/tb.sv
